// File: src/gwt_pkg.sv
package gwt_pkg;

    // Sequencer program counter
    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    // Decimal conversion of the packed value
    localparam int BIN_W       = 30;
    localparam int DIGITS      = 10;
    localparam int DIGIT_IDX_W = 4;
    localparam int BIT_CNT_W   = 5;

    localparam logic [12:0] WEEK_BASE  = 13'd1634;
    localparam logic [10:0] WALK_LIMIT = 11'd1200;
    localparam logic [29:0] MS_IN_DAY  = 30'd86400000;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_DABBLE,
        OP_NOP,
        OP_HORNER,
        OP_CHECK,
        OP_WALK,
        OP_ADD_WD,
        OP_OUT_DATE,
        OP_OUT_REJECT,
        OP_OUT_TIME
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_MORE_BITS,
        C_TIME,
        C_BAD,
        C_WALK
    } cond_t;

    typedef enum logic [1:0] {
        DST_ACC,
        DST_DAY,
        DST_MONTH,
        DST_YEAR
    } dst_t;

    typedef enum logic [1:0] {
        MUL_ZERO,
        MUL_6,
        MUL_10
    } mul_t;

    // One control word of the program
    typedef struct packed {
        op_t                    op;
        cond_t                  cond;
        dst_t                   dst;
        mul_t                   mul;
        logic [DIGIT_IDX_W-1:0] digit;
        pc_t                    target;
    } ctrl_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic hold;
        logic more_bits;
        logic is_time;
        logic bad;
        logic walk_more;
    } stat_t;

    // Program entry points
    localparam pc_t PC_IDLE   = 5'd0;
    localparam pc_t PC_DABBLE = 5'd1;
    localparam pc_t PC_REJECT = 5'd12;
    localparam pc_t PC_WALK   = 5'd10;
    localparam pc_t PC_TIME   = 5'd13;

    function automatic ctrl_t cw(op_t op, cond_t cond, dst_t dst, mul_t mul,
                                 logic [DIGIT_IDX_W-1:0] digit, pc_t target);
        ctrl_t c;
        c.op     = op;
        c.cond   = cond;
        c.dst    = dst;
        c.mul    = mul;
        c.digit  = digit;
        c.target = target;
        return c;
    endfunction

    // Days of a month beyond 28, months numbered 1..12
    function automatic logic [1:0] month_extra(logic [3:0] m);
        logic [1:0] e;
        case (m)
            4'd2:                        e = 2'd0;
            4'd4, 4'd6, 4'd9, 4'd11:     e = 2'd2;
            default:                     e = 2'd3;
        endcase
        return e;
    endfunction

    // Milliseconds at the start of a weekday
    function automatic logic [29:0] wd_ms(logic [2:0] wd);
        logic [29:0] ms;
        case (wd)
            3'd1:    ms = 30'd86400000;
            3'd2:    ms = 30'd172800000;
            3'd3:    ms = 30'd259200000;
            3'd4:    ms = 30'd345600000;
            3'd5:    ms = 30'd432000000;
            3'd6:    ms = 30'd518400000;
            default: ms = 30'd0;
        endcase
        return ms;
    endfunction

endpackage

// File: src/gwt_seq.sv
module gwt_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  gwt_pkg::stat_t  stat_i,
    output gwt_pkg::ctrl_t  ctrl_o
);
    import gwt_pkg::*;

    pc_t   pc_reg;
    pc_t   pc_next;
    ctrl_t ctrl;
    logic  take;

    // Program store
    always_comb begin
        unique case (pc_reg)
            5'd0:    ctrl = cw(OP_IDLE,       C_NEXT,      DST_ACC,   MUL_ZERO, 4'd0, PC_IDLE);
            5'd1:    ctrl = cw(OP_DABBLE,     C_MORE_BITS, DST_ACC,   MUL_ZERO, 4'd0, PC_DABBLE);
            5'd2:    ctrl = cw(OP_NOP,        C_TIME,      DST_ACC,   MUL_ZERO, 4'd0, PC_TIME);
            5'd3:    ctrl = cw(OP_HORNER,     C_NEXT,      DST_DAY,   MUL_ZERO, 4'd5, PC_IDLE);
            5'd4:    ctrl = cw(OP_HORNER,     C_NEXT,      DST_DAY,   MUL_10,   4'd4, PC_IDLE);
            5'd5:    ctrl = cw(OP_HORNER,     C_NEXT,      DST_MONTH, MUL_ZERO, 4'd3, PC_IDLE);
            5'd6:    ctrl = cw(OP_HORNER,     C_NEXT,      DST_MONTH, MUL_10,   4'd2, PC_IDLE);
            5'd7:    ctrl = cw(OP_HORNER,     C_NEXT,      DST_YEAR,  MUL_ZERO, 4'd1, PC_IDLE);
            5'd8:    ctrl = cw(OP_HORNER,     C_NEXT,      DST_YEAR,  MUL_10,   4'd0, PC_IDLE);
            5'd9:    ctrl = cw(OP_CHECK,      C_BAD,       DST_ACC,   MUL_ZERO, 4'd0, PC_REJECT);
            5'd10:   ctrl = cw(OP_WALK,       C_WALK,      DST_ACC,   MUL_ZERO, 4'd0, PC_WALK);
            5'd11:   ctrl = cw(OP_OUT_DATE,   C_JUMP,      DST_ACC,   MUL_ZERO, 4'd0, PC_IDLE);
            5'd12:   ctrl = cw(OP_OUT_REJECT, C_JUMP,      DST_ACC,   MUL_ZERO, 4'd0, PC_IDLE);
            5'd13:   ctrl = cw(OP_HORNER,     C_NEXT,      DST_ACC,   MUL_ZERO, 4'd8, PC_IDLE);
            5'd14:   ctrl = cw(OP_HORNER,     C_NEXT,      DST_ACC,   MUL_10,   4'd7, PC_IDLE);
            5'd15:   ctrl = cw(OP_HORNER,     C_NEXT,      DST_ACC,   MUL_6,    4'd6, PC_IDLE);
            5'd16:   ctrl = cw(OP_HORNER,     C_NEXT,      DST_ACC,   MUL_10,   4'd5, PC_IDLE);
            5'd17:   ctrl = cw(OP_HORNER,     C_NEXT,      DST_ACC,   MUL_6,    4'd4, PC_IDLE);
            5'd18:   ctrl = cw(OP_HORNER,     C_NEXT,      DST_ACC,   MUL_10,   4'd3, PC_IDLE);
            5'd19:   ctrl = cw(OP_HORNER,     C_NEXT,      DST_ACC,   MUL_10,   4'd2, PC_IDLE);
            5'd20:   ctrl = cw(OP_HORNER,     C_NEXT,      DST_ACC,   MUL_10,   4'd1, PC_IDLE);
            5'd21:   ctrl = cw(OP_HORNER,     C_NEXT,      DST_ACC,   MUL_10,   4'd0, PC_IDLE);
            5'd22:   ctrl = cw(OP_ADD_WD,     C_NEXT,      DST_ACC,   MUL_ZERO, 4'd0, PC_IDLE);
            5'd23:   ctrl = cw(OP_OUT_TIME,   C_JUMP,      DST_ACC,   MUL_ZERO, 4'd0, PC_IDLE);
            default: ctrl = cw(OP_NOP,        C_JUMP,      DST_ACC,   MUL_ZERO, 4'd0, PC_IDLE);
        endcase
    end

    always_comb begin
        unique case (ctrl.cond)
            C_NEXT:      take = 1'b0;
            C_JUMP:      take = 1'b1;
            C_MORE_BITS: take = stat_i.more_bits;
            C_TIME:      take = stat_i.is_time;
            C_BAD:       take = stat_i.bad;
            C_WALK:      take = stat_i.walk_more;
            default:     take = 1'b0;
        endcase
        if (stat_i.hold) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl_o = ctrl;

endmodule

// File: src/gwt_dp.sv
module gwt_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  gwt_pkg::ctrl_t  ctrl_i,
    output gwt_pkg::stat_t  stat_o,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            in_mode,
    input  logic [29:0]     in_value,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [12:0]     out_week,
    output logic [29:0]     out_tow,
    output logic            out_ok
);
    import gwt_pkg::*;

    logic [BIN_W-1:0]          bin_reg,   bin_next;
    logic [DIGITS-1:0][3:0]    bcd_reg,   bcd_next;
    logic [BIT_CNT_W-1:0]      cnt_reg,   cnt_next;
    logic                      mode_reg,  mode_next;
    logic [29:0]               acc_reg,   acc_next;
    logic [6:0]                day_reg,   day_next;
    logic [6:0]                month_reg, month_next;
    logic [6:0]                year_reg,  year_next;
    logic [3:0]                m_reg,     m_next;
    logic [6:0]                y_reg,     y_next;
    logic [10:0]               steps_reg, steps_next;
    logic [12:0]               q_reg,     q_next;
    logic [2:0]                r_reg,     r_next;
    logic [2:0]                weekday_reg, weekday_next;
    logic                      ovalid_reg, ovalid_next;
    logic [12:0]               week_reg,  week_next;
    logic [29:0]               tow_reg,   tow_next;
    logic                      ok_reg,    ok_next;

    logic [DIGITS-1:0][3:0]    adj;
    logic [29:0]               base;
    logic [29:0]               prod;
    logic [29:0]               horner_val;
    logic [3:0]                digit;
    logic                      out_busy;
    logic                      bad;
    logic                      walk_more;
    logic [4:0]                dm1;
    logic [3:0]                r_sum;
    logic                      leap;

    // Add 3 to every BCD digit of 5 or more before each shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    assign digit = bcd_reg[ctrl_i.digit];

    always_comb begin
        case (ctrl_i.dst)
            DST_DAY:   base = {23'd0, day_reg};
            DST_MONTH: base = {23'd0, month_reg};
            DST_YEAR:  base = {23'd0, year_reg};
            default:   base = acc_reg;
        endcase
        case (ctrl_i.mul)
            MUL_6:   prod = (base << 2) + (base << 1);
            MUL_10:  prod = (base << 3) + (base << 1);
            default: prod = 30'd0;
        endcase
        horner_val = prod + {26'd0, digit};
    end

    assign bad = (day_reg == 7'd0) || (day_reg > 7'd31)
              || (month_reg == 7'd0) || (month_reg > 7'd12);
    assign walk_more = (({3'd0, m_reg} < month_reg) || (y_reg < year_reg))
                    && (steps_reg <= WALK_LIMIT);
    assign out_busy  = ovalid_reg && !m_tready;
    assign dm1       = day_reg[4:0] - 5'd1;
    assign leap      = (m_reg == 4'd2) && (y_reg[1:0] == 2'd0);
    assign r_sum     = {1'b0, r_reg} + {2'b00, month_extra(m_reg)} + {3'd0, leap};

    always_comb begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        m_next       = m_reg;
        y_next       = y_reg;
        steps_next   = steps_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        weekday_next = weekday_reg;
        week_next    = week_reg;
        tow_next     = tow_reg;
        ok_next      = ok_reg;
        ovalid_next  = ovalid_reg && !m_tready;

        unique case (ctrl_i.op)
            OP_IDLE: begin
                if (s_tvalid) begin
                    bin_next  = in_value;
                    bcd_next  = '0;
                    cnt_next  = BIT_CNT_W'(BIN_W);
                    mode_next = in_mode;
                end
            end
            OP_DABBLE: begin
                bcd_next = {adj[DIGITS-1][2:0], adj[DIGITS-2:0], bin_reg[BIN_W-1]};
                bin_next = {bin_reg[BIN_W-2:0], 1'b0};
                cnt_next = cnt_reg - BIT_CNT_W'(1);
            end
            OP_HORNER: begin
                case (ctrl_i.dst)
                    DST_DAY:   day_next   = horner_val[6:0];
                    DST_MONTH: month_next = horner_val[6:0];
                    DST_YEAR:  year_next  = horner_val[6:0];
                    default:   acc_next   = horner_val;
                endcase
            end
            OP_CHECK: begin
                // Split day-1 into whole weeks and leftover days
                m_next     = 4'd5;
                y_next     = 7'd11;
                steps_next = 11'd0;
                if (dm1 >= 5'd28) begin
                    q_next = 13'd4;
                    r_next = 3'(dm1 - 5'd28);
                end else if (dm1 >= 5'd21) begin
                    q_next = 13'd3;
                    r_next = 3'(dm1 - 5'd21);
                end else if (dm1 >= 5'd14) begin
                    q_next = 13'd2;
                    r_next = 3'(dm1 - 5'd14);
                end else if (dm1 >= 5'd7) begin
                    q_next = 13'd1;
                    r_next = 3'(dm1 - 5'd7);
                end else begin
                    q_next = 13'd0;
                    r_next = dm1[2:0];
                end
            end
            OP_WALK: begin
                if (walk_more) begin
                    // Each month is four weeks plus 0..3 days
                    if (r_sum >= 4'd7) begin
                        r_next = 3'(r_sum - 4'd7);
                        q_next = q_reg + 13'd5;
                    end else begin
                        r_next = r_sum[2:0];
                        q_next = q_reg + 13'd4;
                    end
                    if (m_reg == 4'd12) begin
                        m_next = 4'd1;
                        y_next = y_reg + 7'd1;
                    end else begin
                        m_next = m_reg + 4'd1;
                    end
                    steps_next = steps_reg + 11'd1;
                end
            end
            OP_ADD_WD: begin
                acc_next = acc_reg + wd_ms(weekday_reg);
            end
            OP_OUT_DATE: begin
                if (!out_busy) begin
                    weekday_next = r_reg;
                    week_next    = WEEK_BASE + q_reg;
                    tow_next     = 30'd0;
                    ok_next      = 1'b1;
                    ovalid_next  = 1'b1;
                end
            end
            OP_OUT_REJECT: begin
                if (!out_busy) begin
                    week_next   = 13'd0;
                    tow_next    = 30'd0;
                    ok_next     = 1'b0;
                    ovalid_next = 1'b1;
                end
            end
            OP_OUT_TIME: begin
                if (!out_busy) begin
                    week_next   = 13'd0;
                    tow_next    = acc_reg;
                    ok_next     = 1'b1;
                    ovalid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weekday_reg <= 3'd0;
            ovalid_reg  <= 1'b0;
        end else begin
            weekday_reg <= weekday_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        mode_reg  <= mode_next;
        acc_reg   <= acc_next;
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        m_reg     <= m_next;
        y_reg     <= y_next;
        steps_reg <= steps_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        week_reg  <= week_next;
        tow_reg   <= tow_next;
        ok_reg    <= ok_next;
    end

    always_comb begin
        stat_o.hold      = ((ctrl_i.op == OP_IDLE) && !s_tvalid)
                        || (((ctrl_i.op == OP_OUT_DATE) || (ctrl_i.op == OP_OUT_REJECT)
                             || (ctrl_i.op == OP_OUT_TIME)) && out_busy);
        stat_o.more_bits = (cnt_reg != BIT_CNT_W'(1));
        stat_o.is_time   = mode_reg;
        stat_o.bad       = bad;
        stat_o.walk_more = walk_more;
    end

    assign s_tready = (ctrl_i.op == OP_IDLE);
    assign m_tvalid = ovalid_reg;
    assign out_week = week_reg;
    assign out_tow  = tow_reg;
    assign out_ok   = ok_reg;

endmodule

// File: src/gps_week_and_time_of_week.sv
// GPS week number and time of week from decimal-packed NMEA-style values.
// Input channel: s_tuser selects the item kind (0 = DDMMYY date,
// 1 = HHMMSSmmm time), s_tdata[29:0] holds the decimal-packed value.
// Result channel: one item per input item; m_tdata carries week number
// and milliseconds into the week, m_tuser flags an accepted item.
// An accepted date item sets the stored weekday used by later time items.
// Timing: a small microcoded sequencer steps one control word per cycle,
// but holds while idle with no input, or at an output step while the last
// result is still untaken. Every item is first converted from binary to BCD.
// A date then has day and month checked, and an accepted date walks months
// on from May 2011, up to December 2099; the month walk sets the worst case.
// The next item is taken once the sequencer is back at its idle step.
// The result sits in an output register: the block accepts the next item
// while it waits, and stalls only at the step that would overwrite it.
// Reset (aresetn low, synchronous) returns the sequencer to idle, empties
// the output register and sets the stored weekday to Sunday.
module gps_week_and_time_of_week (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [29:0] value, [31:30] zero
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [12:0] week_number, [42:13] time_of_week_ms, [47:43] zero
    output logic        m_tuser    // [0] accepted
);
    import gwt_pkg::*;

    ctrl_t       ctrl;
    stat_t       stat;
    logic [12:0] week;
    logic [29:0] tow;

    gwt_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat_i  (stat),
        .ctrl_o  (ctrl)
    );

    gwt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_i   (ctrl),
        .stat_o   (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_mode  (s_tuser),
        .in_value (s_tdata[29:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_week (week),
        .out_tow  (tow),
        .out_ok   (m_tuser)
    );

    assign m_tdata = {5'd0, tow, week};

endmodule

// File: tb/sv/gwt_tb_pkg.sv
package gwt_tb_pkg;

    import gwt_pkg::*;

    // Item kinds carried on s_tuser
    localparam logic KIND_DATE = 1'b0;
    localparam logic KIND_TIME = 1'b1;

    // Month lengths, January first
    localparam logic [0:11][4:0] MONTH_DAYS = {
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [12:0] week;
        logic [29:0] tow_ms;
        logic        accepted;
    } gps_fix_t;

    class week_time_scoreboard;

        logic [2:0]  weekday;
        gps_fix_t    pending_fixes[$];
        int unsigned failures;
        int unsigned dates_taken;
        int unsigned dates_refused;
        int unsigned times_taken;
        int unsigned results_checked;

        function new();
            weekday         = 3'd0;
            failures        = 0;
            dates_taken     = 0;
            dates_refused   = 0;
            times_taken     = 0;
            results_checked = 0;
        endfunction

        // Work out the fix for one item; an accepted date sets the stored weekday
        function gps_fix_t predict_fix(logic kind, logic [29:0] value);
            gps_fix_t    fix;
            int unsigned v, yy, mm, dd, m, y, steps;
            int unsigned hh, mi, ss, ms, tow;
            fix = '0;
            v   = value;
            if (kind == KIND_DATE) begin
                yy = v % 100;
                mm = (v / 100) % 100;
                dd = (v / 10000) % 100;
                if (dd >= 1 && dd <= 31 && mm >= 1 && mm <= 12) begin
                    m     = 5;
                    y     = 11;
                    steps = 0;
                    // walk months forward from May 2011
                    while (m < mm || y < yy) begin
                        dd += MONTH_DAYS[(m - 1) % 12];
                        if (m == 2 && (y % 4) == 0 && (y % 100) != 0)
                            dd++;
                        m++;
                        if (m == 13) begin
                            m = 1;
                            y++;
                        end
                        steps++;
                        if (steps > WALK_LIMIT)
                            break;
                    end
                    weekday      = 3'((dd - 1) % 7);
                    fix.week     = 13'(WEEK_BASE + (dd - 1) / 7);
                    fix.accepted = 1'b1;
                end
            end else begin
                ms  = v % 1000;
                ss  = (v / 1000) % 100;
                mi  = (v / 100000) % 100;
                hh  = (v / 10000000) % 100;
                tow = ((hh * 60 + mi) * 60 + ss) * 1000 + ms
                      + (int'(weekday) % 7) * int'(MS_IN_DAY);
                fix.tow_ms   = 30'(tow);
                fix.accepted = 1'b1;
            end
            return fix;
        endfunction

        function void note_item(logic kind, logic [29:0] value);
            gps_fix_t fix;
            fix = predict_fix(kind, value);
            if (kind == KIND_TIME)
                times_taken++;
            else if (fix.accepted)
                dates_taken++;
            else
                dates_refused++;
            pending_fixes.push_back(fix);
        endfunction

        function void check_result(logic [12:0] week, logic [29:0] tow_ms, logic accepted);
            gps_fix_t want;
            if (pending_fixes.size() == 0) begin
                $error("result with no item pending: week %0d, tow %0d, accepted %0b",
                       week, tow_ms, accepted);
                failures++;
                return;
            end
            want = pending_fixes.pop_front();
            results_checked++;
            if (week !== want.week) begin
                $error("week_number: expected %0d, got %0d", want.week, week);
                failures++;
            end
            if (tow_ms !== want.tow_ms) begin
                $error("time_of_week_ms: expected %0d, got %0d", want.tow_ms, tow_ms);
                failures++;
            end
            if (accepted !== want.accepted) begin
                $error("accepted: expected %0b, got %0b", want.accepted, accepted);
                failures++;
            end
        endfunction

    endclass

endpackage

// File: tb/sv/gps_week_and_time_of_week_test.sv
module gps_week_and_time_of_week_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gwt_pkg::*;
    import gwt_tb_pkg::*;

    localparam int STALL_LIMIT  = 6000;
    localparam int RANDOM_ITEMS = 460;
    localparam int DRAIN_CYCLES = 1200;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    week_time_scoreboard gps_sb;
    int                  burst_left;
    int                  idle_cycles;

    gps_week_and_time_of_week dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: rotate a stall pattern, reload it every so often
    initial begin : receiver
        logic [15:0] stall_pattern;
        int          hold;
        stall_pattern = '1;
        hold          = 0;
        forever begin
            @(posedge aclk);
            if (hold == 0) begin
                hold          = $urandom_range(64, 256);
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end else begin
                hold--;
            end
            m_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            gps_sb.check_result(m_tdata[12:0], m_tdata[42:13], m_tuser);
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("gps_week_and_time_of_week regression: fail");
        $finish;
    end

    // Offer one item; open a new burst after a random gap when the last one ran out
    task automatic send_item(input logic kind, input int unsigned value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, 30'(value)};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gps_sb.note_item(kind, 30'(value));
        burst_left--;
    endtask

    // Hold the sender until every pending result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (gps_sb.pending_fixes.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    initial begin
        int unsigned dd, mm, yy, high, value;
        int          pick;
        gps_sb     = new();
        burst_left = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // time at reset weekday, digit extremes, rejected dates
        send_item(KIND_TIME, 0);
        send_item(KIND_TIME, 999999999);
        send_item(KIND_DATE, 0);
        send_item(KIND_DATE, 10511);
        send_item(KIND_DATE, 511);
        send_item(KIND_DATE, 320511);
        send_item(KIND_DATE, 150011);
        send_item(KIND_DATE, 151311);
        send_item(KIND_DATE, 311299);
        send_item(KIND_TIME, 235959999);
        // rejected date keeps the weekday of the one before it
        send_item(KIND_DATE, 21115);
        send_item(KIND_DATE, 991399);
        send_item(KIND_TIME, 123456789);
        send_item(KIND_DATE, 10100);
        send_item(KIND_TIME, 60000);
        // years before 2011, impossible day, leap February, high digits
        send_item(KIND_DATE, 150305);
        send_item(KIND_DATE, 150805);
        send_item(KIND_DATE, 310213);
        send_item(KIND_DATE, 290212);
        send_item(KIND_DATE, 999311299);
        send_item(KIND_TIME, 0);
        send_item(KIND_DATE, 536870911);
        send_item(KIND_TIME, 500000000);
        send_item(KIND_DATE, 310599);
        send_item(KIND_TIME, 1000);
        settle();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                dd    = $urandom_range(1, 31);
                mm    = $urandom_range(1, 12);
                yy    = $urandom_range(0, 99);
                high  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 999) : 0;
                value = high * 1000000 + dd * 10000 + mm * 100 + yy;
                send_item(KIND_DATE, value);
            end else if (pick < 58) begin
                case ($urandom_range(0, 2))
                    0: begin
                        dd = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(32, 99);
                        mm = $urandom_range(0, 99);
                    end
                    1: begin
                        dd = $urandom_range(1, 31);
                        mm = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
                    end
                    default: begin
                        dd = 0;
                        mm = 0;
                    end
                endcase
                value = dd * 10000 + mm * 100 + $urandom_range(0, 99);
                if (dd == 0 && mm == 0)
                    value = $urandom_range(0, 999999999);
                send_item(KIND_DATE, value);
            end else if (pick < 90) begin
                value = $urandom_range(0, 23) * 10000000 + $urandom_range(0, 59) * 100000
                        + $urandom_range(0, 59) * 1000 + $urandom_range(0, 999);
                send_item(KIND_TIME, value);
            end else begin
                send_item(KIND_TIME, $urandom_range(0, 999999999));
            end
            if (i == RANDOM_ITEMS / 2)
                settle();
        end
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d accepted dates, %0d rejected dates, %0d time items",
                 gps_sb.dates_taken, gps_sb.dates_refused, gps_sb.times_taken);
        $display("checked %0d results, %0d mismatches",
                 gps_sb.results_checked, gps_sb.failures);
        if (gps_sb.failures == 0)
            $display("gps_week_and_time_of_week regression: pass");
        else
            $display("gps_week_and_time_of_week regression: fail");
        $finish;
    end

endmodule
